// File: hw/rtl/spiq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spiq_pkg
// Shared types and constants for the sorted insert priority queue.
// ----------------------------------------------------------------------------
package spiq_pkg;

  localparam int DEPTH  = 16;
  localparam int PRIO_W = 16;
  localparam int DATA_W = 32;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CAP_W  = 5;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_REMOVE = 1'b1
  } req_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic clear;
    logic cmp;
    logic ins;
    logic rem;
  } cell_ctrl_t;

endpackage : spiq_pkg
`default_nettype wire

// File: hw/rtl/spiq_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spiq_cell
// One slot of the sorted chain: holds an entry, compares it against the
// incoming key, and shifts toward the back on insert or the front on remove.
// ----------------------------------------------------------------------------
module spiq_cell import spiq_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cell_ctrl_t        ctrl,
  input  wire logic [PRIO_W-1:0] key,
  input  wire logic [PRIO_W-1:0] new_prio,
  input  wire logic [DATA_W-1:0] new_data,
  input  wire logic              left_keep,
  input  wire logic              left_valid,
  input  wire logic [PRIO_W-1:0] left_prio,
  input  wire logic [DATA_W-1:0] left_data,
  input  wire logic              right_valid,
  input  wire logic [PRIO_W-1:0] right_prio,
  input  wire logic [DATA_W-1:0] right_data,
  output logic                   valid,
  output logic                   keep,
  output logic      [PRIO_W-1:0] prio,
  output logic      [DATA_W-1:0] data
);

  logic              valid_r, valid_nxt;
  logic              keep_r, keep_nxt;
  logic [PRIO_W-1:0] prio_r, prio_nxt;
  logic [DATA_W-1:0] data_r, data_nxt;

  always_comb begin
    valid_nxt = valid_r;
    keep_nxt  = keep_r;
    prio_nxt  = prio_r;
    data_nxt  = data_r;
    if (ctrl.clear) begin
      valid_nxt = 1'b0;
    end else if (ctrl.cmp) begin
      keep_nxt = valid_r && ($signed(prio_r) >= $signed(key));
    end else if (ctrl.ins) begin
      if (!keep_r) begin
        if (left_keep) begin
          valid_nxt = 1'b1;
          prio_nxt  = new_prio;
          data_nxt  = new_data;
        end else begin
          valid_nxt = left_valid;
          prio_nxt  = left_prio;
          data_nxt  = left_data;
        end
      end
    end else if (ctrl.rem) begin
      valid_nxt = right_valid;
      prio_nxt  = right_prio;
      data_nxt  = right_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      keep_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      keep_r  <= keep_nxt;
    end
    prio_r <= prio_nxt;
    data_r <= data_nxt;
  end

  assign valid = valid_r;
  assign keep  = keep_r;
  assign prio  = prio_r;
  assign data  = data_r;

endmodule : spiq_cell
`default_nettype wire

// File: hw/rtl/sorted_insert_priority_queue_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_insert_priority_queue_top
// Priority queue kept sorted in a chain of cells, highest priority in front,
// equal priorities in arrival order.
//
//   channel  | handshake            | word
//   ---------+----------------------+-----------------------------------------
//   in_      | start / busy         | req_type, new_prio, new_data
//   out_     | out_valid (strobe)   | status, prio, data, entry_count, flags
//   cfg_     | cfg_valid / cfg_ready| capacity
//
// Each request has a compare step, which compares the key in every cell, then
// a shift step of the chain. busy is high in the shift cycle; the result
// strobes the cycle after. Synchronous reset empties the queue and sets capacity
// to DEPTH. The receiver cannot stall; a capacity write empties the queue.
// ----------------------------------------------------------------------------
module sorted_insert_priority_queue_top import spiq_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              in_req_type,
  input  wire logic [PRIO_W-1:0] in_new_prio,
  input  wire logic [DATA_W-1:0] in_new_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CAP_W-1:0]  cfg_capacity,
  output logic                   out_valid,
  output logic [1:0]             out_status,
  output logic [PRIO_W-1:0]      out_prio,
  output logic [DATA_W-1:0]      out_data,
  output logic [CNT_W-1:0]       out_entry_count,
  output logic                   out_is_empty,
  output logic                   out_is_full
);

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  cap_r, cap_nxt;
  logic              req_r;
  logic [PRIO_W-1:0] prio_r;
  logic [DATA_W-1:0] data_r;

  logic              ovalid_r, ovalid_nxt;
  status_t           ostat_r, ostat_nxt;
  logic [PRIO_W-1:0] oprio_r, oprio_nxt;
  logic [DATA_W-1:0] odata_r, odata_nxt;
  logic [CNT_W-1:0]  ocnt_r;
  logic              oempty_r, ofull_r;

  cell_ctrl_t        ctrl;
  logic              accept, cfg_wr;
  logic [CAP_W-1:0]  cap_clamp;

  logic [DEPTH-1:0]  c_valid, c_keep;
  logic [PRIO_W-1:0] c_prio [DEPTH];
  logic [DATA_W-1:0] c_data [DEPTH];

  assign accept = start && (state_r == S_IDLE);
  assign cfg_wr = cfg_valid && cfg_ready;

  always_comb begin
    cap_clamp = cfg_capacity;
    if (cfg_capacity == '0) begin
      cap_clamp = CAP_W'(1);
    end else if (cfg_capacity > CAP_W'(DEPTH)) begin
      cap_clamp = CAP_W'(DEPTH);
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    cap_nxt    = cap_r;
    ctrl       = '0;
    ovalid_nxt = 1'b0;
    ostat_nxt  = STAT_DONE;
    oprio_nxt  = '0;
    odata_nxt  = '0;
    case (state_r)
      S_IDLE: begin
        if (cfg_wr) begin
          cap_nxt    = CNT_W'(cap_clamp);
          cnt_nxt    = '0;
          ctrl.clear = 1'b1;
        end else if (accept) begin
          ctrl.cmp  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        ovalid_nxt = 1'b1;
        state_nxt  = S_IDLE;
        if (req_r == REQ_INSERT) begin
          if (cnt_r >= cap_r) begin
            ostat_nxt = STAT_FULL;
          end else begin
            ctrl.ins = 1'b1;
            cnt_nxt  = cnt_r + CNT_W'(1);
          end
        end else begin
          if (cnt_r == '0) begin
            ostat_nxt = STAT_EMPTY;
          end else begin
            ctrl.rem  = 1'b1;
            oprio_nxt = c_prio[0];
            odata_nxt = c_data[0];
            cnt_nxt   = cnt_r - CNT_W'(1);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      cap_r    <= CNT_W'(DEPTH);
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      cap_r    <= cap_nxt;
      ovalid_r <= ovalid_nxt;
    end
    if (accept) begin
      req_r  <= in_req_type;
      prio_r <= in_new_prio;
      data_r <= in_new_data;
    end
    ostat_r  <= ostat_nxt;
    oprio_r  <= oprio_nxt;
    odata_r  <= odata_nxt;
    ocnt_r   <= cnt_nxt;
    oempty_r <= (cnt_nxt == '0);
    ofull_r  <= (cnt_nxt == cap_r);
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic              lk, lv, rv;
    logic [PRIO_W-1:0] lp, rp;
    logic [DATA_W-1:0] ld, rd;
    if (i == 0) begin : g_first
      assign lk = 1'b1;
      assign lv = 1'b0;
      assign lp = '0;
      assign ld = '0;
    end else begin : g_mid
      assign lk = c_keep[i-1];
      assign lv = c_valid[i-1];
      assign lp = c_prio[i-1];
      assign ld = c_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign rv = 1'b0;
      assign rp = '0;
      assign rd = '0;
    end else begin : g_body
      assign rv = c_valid[i+1];
      assign rp = c_prio[i+1];
      assign rd = c_data[i+1];
    end
    spiq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .key        (in_new_prio),
      .new_prio   (prio_r),
      .new_data   (data_r),
      .left_keep  (lk),
      .left_valid (lv),
      .left_prio  (lp),
      .left_data  (ld),
      .right_valid(rv),
      .right_prio (rp),
      .right_data (rd),
      .valid      (c_valid[i]),
      .keep       (c_keep[i]),
      .prio       (c_prio[i]),
      .data       (c_data[i])
    );
  end

  assign busy            = (state_r != S_IDLE);
  // a pending request takes the idle cycle, so a capacity write waits
  assign cfg_ready       = (state_r == S_IDLE) && !start;
  assign out_valid       = ovalid_r;
  assign out_status      = ostat_r;
  assign out_prio        = oprio_r;
  assign out_data        = odata_r;
  assign out_entry_count = ocnt_r;
  assign out_is_empty    = oempty_r;
  assign out_is_full     = ofull_r;

  a_cnt_le_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= cap_r) else $error("entry count above capacity");

  a_valid_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(c_valid) == 32'(cnt_r)) else $error("cell valid bits disagree with count");

  a_out_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_EXEC)) else $error("result without execute cycle");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && req_r == REQ_REMOVE && cnt_r != '0)
      |=> cnt_r == $past(cnt_r) - CNT_W'(1)) else $error("remove did not shrink queue");

endmodule : sorted_insert_priority_queue_top
`default_nettype wire

// File: tb/sv/tb_sorted_insert_priority_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_insert_priority_queue_top
// Self-checking bench for the sorted insert priority queue. A clocked driver
// feeds requests from a backlog and keeps a software copy of the sorted store
// to predict each result word; a clocked monitor compares every strobed
// result with the oldest prediction. Runs directed corner cases, then random
// fill/drain traffic over a range of capacity settings.
// ----------------------------------------------------------------------------
module tb_sorted_insert_priority_queue_top;
  import spiq_pkg::*;

  localparam int STALL_LIMIT = 2000;

  typedef struct {
    req_t              kind;
    logic [PRIO_W-1:0] prio;
    logic [DATA_W-1:0] data;
    int                gap;
  } request_t;

  typedef struct {
    status_t           status;
    logic [PRIO_W-1:0] prio;
    logic [DATA_W-1:0] data;
    logic [CNT_W-1:0]  count;
    logic              empty;
    logic              full;
  } reply_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic              in_req_type = 1'b0;
  logic [PRIO_W-1:0] in_new_prio = '0;
  logic [DATA_W-1:0] in_new_data = '0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CAP_W-1:0]  cfg_capacity = '0;
  logic              out_valid;
  logic [1:0]        out_status;
  logic [PRIO_W-1:0] out_prio;
  logic [DATA_W-1:0] out_data;
  logic [CNT_W-1:0]  out_entry_count;
  logic              out_is_empty;
  logic              out_is_full;

  sorted_insert_priority_queue_top uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_req_type     (in_req_type),
    .in_new_prio     (in_new_prio),
    .in_new_data     (in_new_data),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_capacity    (cfg_capacity),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_prio        (out_prio),
    .out_data        (out_data),
    .out_entry_count (out_entry_count),
    .out_is_empty    (out_is_empty),
    .out_is_full     (out_is_full)
  );

  request_t request_backlog[$];
  reply_t   reply_fifo[$];
  int       items_queued = 0;
  int       items_accepted = 0;
  int       mismatches = 0;
  int       gap_left = 0;
  int       stall_cycles = 0;

  // shadow of the sorted store
  logic signed [PRIO_W-1:0] prio_mem [DEPTH];
  logic [DATA_W-1:0]        data_mem [DEPTH];
  int                       q_front = 0;
  int                       q_held = 0;
  int                       q_cap = DEPTH;

  int phase_caps[8]  = '{31, 0, 3, 16, 17, 2, 8, 1};
  int phase_items[8] = '{200, 60, 120, 250, 90, 80, 100, 60};

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int slot(input int logical);
    return (q_front + logical) % q_cap;
  endfunction

  task automatic set_capacity(input logic [CAP_W-1:0] v);
    q_cap   = (v == 0) ? 1 : ((v > DEPTH) ? DEPTH : int'(v));
    q_front = 0;
    q_held  = 0;
  endtask

  task automatic serve_request(input req_t kind, input logic signed [PRIO_W-1:0] key,
                               input logic [DATA_W-1:0] payload);
    reply_t r;
    int     pos;
    int     k;
    r = '{STAT_DONE, '0, '0, '0, 1'b0, 1'b0};
    if (kind == REQ_INSERT) begin
      if (q_held >= q_cap) begin
        r.status = STAT_FULL;
      end else begin
        pos = 0;
        while (pos < q_held && prio_mem[slot(pos)] >= key) pos++;
        for (k = q_held; k > pos; k--) begin
          prio_mem[slot(k)] = prio_mem[slot(k - 1)];
          data_mem[slot(k)] = data_mem[slot(k - 1)];
        end
        prio_mem[slot(pos)] = key;
        data_mem[slot(pos)] = payload;
        q_held++;
      end
    end else begin
      if (q_held == 0) begin
        r.status = STAT_EMPTY;
      end else begin
        r.prio  = prio_mem[slot(0)];
        r.data  = data_mem[slot(0)];
        q_front = (q_front + 1) % q_cap;
        q_held--;
      end
    end
    r.count = q_held[CNT_W-1:0];
    r.empty = (q_held == 0);
    r.full  = (q_held == q_cap);
    reply_fifo.push_back(r);
  endtask

  task automatic note_mismatch(input string msg);
    mismatches++;
    $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  task automatic queue_request(input req_t kind, input logic [PRIO_W-1:0] p,
                               input logic [DATA_W-1:0] d, input int gap);
    request_backlog.push_back('{kind, p, d, gap});
    items_queued++;
  endtask

  // sender holds until every word is accepted and every result is back
  task automatic drain();
    while (items_accepted != items_queued || reply_fifo.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] v);
    cfg_capacity <= v;
    cfg_valid    <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_burst(input int n);
    int                i;
    int                ins_pct;
    int                gap_max;
    req_t              kind;
    logic [PRIO_W-1:0] p;
    ins_pct = 50;
    gap_max = 0;
    for (i = 0; i < n; i++) begin
      // change the fill/drain bias and idling every 20 words
      if (i % 20 == 0) begin
        ins_pct = 20 + 30 * $urandom_range(0, 2);
        gap_max = ($urandom_range(0, 2) == 0) ? 0 : 16;
      end
      kind = ($urandom_range(0, 99) < ins_pct) ? REQ_INSERT : REQ_REMOVE;
      case ($urandom_range(0, 3))
        0:       p = PRIO_W'($urandom);
        1:       p = PRIO_W'($urandom_range(0, 6) - 3);
        2:       p = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
        default: p = PRIO_W'($urandom_range(0, 15));
      endcase
      queue_request(kind, p, $urandom, $urandom_range(0, gap_max));
    end
  endtask

  // driver + predictor
  always @(posedge clk) begin : drive
    request_t nxt;
    if (!rst_n) begin
      start    <= 1'b0;
      gap_left <= 0;
      set_capacity(DEPTH[CAP_W-1:0]);
    end else begin
      if (cfg_valid && cfg_ready) set_capacity(cfg_capacity);
      if (start && !busy) begin
        serve_request(req_t'(in_req_type), in_new_prio, in_new_data);
        items_accepted++;
      end
      if (!start || !busy) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          start    <= 1'b0;
        end else if (request_backlog.size() != 0) begin
          nxt = request_backlog.pop_front();
          in_req_type <= nxt.kind;
          in_new_prio <= nxt.prio;
          in_new_data <= nxt.data;
          start       <= 1'b1;
          gap_left    <= nxt.gap;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : watch
    reply_t want;
    if (rst_n && out_valid) begin
      if (reply_fifo.size() == 0) begin
        note_mismatch("result with no request outstanding");
      end else begin
        want = reply_fifo.pop_front();
        if (out_status !== want.status)
          note_mismatch($sformatf("status %0d, want %0d", out_status, want.status));
        if (out_prio !== want.prio)
          note_mismatch($sformatf("prio %h, want %h", out_prio, want.prio));
        if (out_data !== want.data)
          note_mismatch($sformatf("data %h, want %h", out_data, want.data));
        if (out_entry_count !== want.count)
          note_mismatch($sformatf("count %0d, want %0d", out_entry_count, want.count));
        if (out_is_empty !== want.empty)
          note_mismatch($sformatf("empty %b, want %b", out_is_empty, want.empty));
        if (out_is_full !== want.full)
          note_mismatch($sformatf("full %b, want %b", out_is_full, want.full));
      end
    end
  end

  // watchdog: cycles with work outstanding but no handshake
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (items_accepted != items_queued || reply_fifo.size() != 0 || cfg_valid) begin
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb_sorted_insert_priority_queue_top: done, errors");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset capacity: empty remove, extremes, ties in arrival order
    queue_request(REQ_REMOVE, '0, '0, 0);
    queue_request(REQ_INSERT, 16'h7fff, 32'h7fffffff, 0);
    queue_request(REQ_INSERT, 16'h8000, 32'h80000000, 2);
    queue_request(REQ_INSERT, 16'h0000, 32'h00000000, 0);
    queue_request(REQ_INSERT, 16'hffff, 32'hffffffff, 0);
    queue_request(REQ_INSERT, 16'd5, 32'h0000000a, 1);
    queue_request(REQ_INSERT, 16'd5, 32'h0000000b, 0);
    queue_request(REQ_INSERT, 16'd5, 32'h0000000c, 0);
    queue_request(REQ_INSERT, 16'd1, 32'h5a5a5a5a, 3);
    repeat (9) queue_request(REQ_REMOVE, 16'hffff, 32'hffffffff, 0);
    drain();

    // capacity 2: full reject, front wrap, empty reject
    write_capacity(5'd2);
    queue_request(REQ_INSERT, 16'd3, 32'h11111111, 0);
    queue_request(REQ_INSERT, 16'd7, 32'h22222222, 0);
    queue_request(REQ_INSERT, 16'd9, 32'h33333333, 0);
    queue_request(REQ_REMOVE, '0, '0, 0);
    queue_request(REQ_INSERT, 16'hfff0, 32'h44444444, 1);
    queue_request(REQ_REMOVE, '0, '0, 0);
    queue_request(REQ_REMOVE, '0, '0, 0);
    queue_request(REQ_REMOVE, '0, '0, 0);
    drain();

    foreach (phase_caps[j]) begin
      write_capacity(phase_caps[j][CAP_W-1:0]);
      random_burst(phase_items[j]);
      drain();
    end
    write_capacity(CAP_W'($urandom_range(1, 16)));
    random_burst(100);
    drain();

    if (mismatches == 0) begin
      $display("tb_sorted_insert_priority_queue_top: done, clean");
    end else begin
      $display("tb_sorted_insert_priority_queue_top: done, errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/spiq_pkg.sv
hw/rtl/spiq_cell.sv
hw/rtl/sorted_insert_priority_queue_top.sv
tb/sv/tb_sorted_insert_priority_queue_top.sv
